### hw/rtl/ect_pkg.sv
// ----------------------------------------------------------------------------
// ect_pkg
// Types, constants and calendar helpers for the epoch seconds to calendar
// converter.
// ----------------------------------------------------------------------------
package ect_pkg;

  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned DVS_W   = 17;
  localparam int unsigned STEP_W  = 2;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned DAYS_W  = 16;
  localparam int unsigned START_W = 17;
  localparam int unsigned YDAY_W  = 9;
  localparam int unsigned MUL_A_W = 25;
  localparam int unsigned MUL_B_W = 26;
  localparam int unsigned PROD_W  = 51;

  localparam logic [DVS_W-1:0]  SECS_PER_DAY   = 17'd86400;
  localparam logic [DVS_W-1:0]  SECS_PER_HOUR  = 17'd3600;
  localparam logic [DVS_W-1:0]  SECS_PER_MIN   = 17'd60;
  localparam logic [DVS_W-1:0]  DAYS_PER_WEEK  = 17'd7;

  // divisor split into a power of two and an odd part, odd part by reciprocal
  localparam int unsigned PRE_DAY  = 7;
  localparam int unsigned PRE_HOUR = 4;
  localparam int unsigned PRE_MIN  = 2;
  localparam int unsigned PRE_WEEK = 0;
  localparam int unsigned RSH_DAY  = 35;
  localparam int unsigned RSH_HOUR = 21;
  localparam int unsigned RSH_MIN  = 14;
  localparam int unsigned RSH_WEEK = 19;

  localparam logic [MUL_B_W-1:0] RECIP_DAY  = 26'd50903317;
  localparam logic [MUL_B_W-1:0] RECIP_HOUR = 26'd9321;
  localparam logic [MUL_B_W-1:0] RECIP_MIN  = 26'd1093;
  localparam logic [MUL_B_W-1:0] RECIP_WEEK = 26'd74899;

  localparam logic [STEP_W-1:0] DIV_STEP_RECIP = 2'd3;
  localparam logic [STEP_W-1:0] DIV_STEP_BACK  = 2'd2;
  localparam logic [STEP_W-1:0] DIV_STEP_REM   = 2'd1;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR       = 12'd1970;
  localparam logic [YEAR_W-1:0] BASE_YEAR        = 12'd1900;
  localparam logic [YEAR_W-1:0] CENTURY_NON_LEAP = 12'd2100;
  localparam logic [DAYS_W-1:0] EPOCH_WEEKDAY    = 16'd4;
  localparam logic [YDAY_W-1:0] LEAP_YEAR_DAYS   = 9'd366;
  localparam logic [YDAY_W-1:0] COMMON_YEAR_DAYS = 9'd365;
  localparam logic [3:0]        LAST_MONTH       = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAYS,
    ST_HOUR,
    ST_MIN,
    ST_WDAY,
    ST_YEAR,
    ST_MONTH,
    ST_EMIT
  } ect_state_t;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN,
    DIV_WEEK
  } div_op_t;

  typedef struct packed {
    logic                 start;
    div_op_t              op;
    logic [EPOCH_W-1:0]   dividend;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DAYS_W-1:0]    quotient;
    logic [DVS_W-1:0]     remainder;
  } div_rsp_t;

  // valid for years 1970 to 2106, where 2000 is the only century leap year
  function automatic logic leap_year(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'b00) && (y != CENTURY_NON_LEAP);
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### hw/rtl/ect_div.sv
// ----------------------------------------------------------------------------
// ect_div
// Shared divider for the fixed divisors. One multiplier is used twice per
// request: first by a scaled reciprocal for the quotient, then by the divisor
// for the remainder. Done is raised after the recip, back and rem steps.
// ----------------------------------------------------------------------------
module ect_div (
  input  logic          clk,
  input  logic          rst_n,
  input  ect_pkg::div_req_t req,
  output ect_pkg::div_rsp_t rsp
);
  import ect_pkg::*;

  logic [EPOCH_W-1:0] num_r;
  div_op_t            op_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DAYS_W-1:0]  quo_r;
  logic [DVS_W-1:0]   rem_r;
  logic [STEP_W-1:0]  step_r;
  logic               done_r;
  logic [MUL_A_W-1:0] num_pre;
  logic [MUL_B_W-1:0] recip;
  logic [DVS_W-1:0]   dvs_sel;
  logic [DAYS_W-1:0]  quo_sel;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [EPOCH_W-1:0] rem_full;

  always_comb begin
    case (op_r)
      DIV_HOUR: begin
        num_pre = MUL_A_W'(num_r >> PRE_HOUR);
        recip   = RECIP_HOUR;
        dvs_sel = SECS_PER_HOUR;
        quo_sel = prod_r[RSH_HOUR +: DAYS_W];
      end
      DIV_MIN: begin
        num_pre = MUL_A_W'(num_r >> PRE_MIN);
        recip   = RECIP_MIN;
        dvs_sel = SECS_PER_MIN;
        quo_sel = prod_r[RSH_MIN +: DAYS_W];
      end
      DIV_WEEK: begin
        num_pre = MUL_A_W'(num_r >> PRE_WEEK);
        recip   = RECIP_WEEK;
        dvs_sel = DAYS_PER_WEEK;
        quo_sel = prod_r[RSH_WEEK +: DAYS_W];
      end
      default: begin
        num_pre = MUL_A_W'(num_r >> PRE_DAY);
        recip   = RECIP_DAY;
        dvs_sel = SECS_PER_DAY;
        quo_sel = prod_r[RSH_DAY +: DAYS_W];
      end
    endcase
    if (step_r == DIV_STEP_RECIP) begin
      mul_a = num_pre;
      mul_b = recip;
    end else begin
      mul_a = MUL_A_W'(quo_sel);
      mul_b = MUL_B_W'(dvs_sel);
    end
    mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
    rem_full = num_r - prod_r[EPOCH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      step_r <= DIV_STEP_RECIP;
      done_r <= 1'b0;
    end else begin
      done_r <= (step_r == DIV_STEP_REM);
      if (step_r != '0) begin
        step_r <= step_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.dividend;
      op_r  <= req.op;
    end else begin
      case (step_r)
        DIV_STEP_RECIP: prod_r <= mul_p;
        DIV_STEP_BACK: begin
          quo_r  <= quo_sel;
          prod_r <= mul_p;
        end
        DIV_STEP_REM: rem_r <= rem_full[DVS_W-1:0];
        default: ;
      endcase
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

`ifndef SYNTHESIS
  a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!req.start && step_r == DIV_STEP_REM) |=> done_r)
    else $error("divider done missing after last step");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_sel))
    else $error("divider remainder not below divisor");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (step_r == '0))
    else $error("divider done while still stepping");

  a_quotient_exact: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (EPOCH_W'(quo_r) * EPOCH_W'(dvs_sel) + EPOCH_W'(rem_r) == num_r))
    else $error("divider quotient and remainder do not rebuild the dividend");
`endif

endmodule

### hw/rtl/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts seconds since 1970-01-01 UTC into calendar fields by a sequencer
// around one shared divider, a year walk and a month walk.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, in_epoch_seconds
//  out     | output    | out_valid, out_stall, out_in_range ... out_year_day
//
//  one transfer takes 4 passes through the shared divider, then a year walk
//  from 1970 until the day count falls in a year or END_YEAR is reached, a
//  month walk over at most 12 months, the load of the result register and a
//  return to idle; the next timestamp is taken only after that load
//  in_stall is high in reset and from acceptance until the result is loaded
//  a result held by out_stall only delays the load of the next one
//  reset is synchronous and clears only the control state
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar #(
  parameter int unsigned END_YEAR = 2100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_in_range,
  output logic [7:0]  out_years_since_1900,
  output logic [3:0]  out_month_index,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [2:0]  out_weekday,
  output logic [8:0]  out_year_day
);
  import ect_pkg::*;

  localparam logic [YEAR_W-1:0] END_YEAR_W = YEAR_W'(END_YEAR);

  ect_state_t state_r, state_nxt;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  logic [DAYS_W-1:0]  days_r;
  logic [4:0]         hour_r;
  logic [5:0]         minute_r;
  logic [5:0]         second_r;
  logic [2:0]         weekday_r;
  logic [YEAR_W-1:0]  year_r;
  logic [START_W-1:0] start_r;
  logic [YDAY_W-1:0]  left_r;
  logic [YDAY_W-1:0]  yday_r;
  logic [3:0]         month_r;
  logic               leap_r;
  logic               found_r;

  logic               year_past_end;
  logic               year_leap;
  logic [START_W-1:0] year_end;
  logic               year_hit;
  logic [YDAY_W-1:0]  yday_calc;
  logic [4:0]         mlen;
  logic               month_step;
  logic               out_load;
  logic               out_valid_r;

  ect_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    year_past_end = (year_r >= END_YEAR_W);
    year_leap     = leap_year(year_r);
    year_end      = start_r + START_W'(year_leap ? LEAP_YEAR_DAYS : COMMON_YEAR_DAYS);
    year_hit      = ({1'b0, days_r} < year_end);
    yday_calc     = YDAY_W'({1'b0, days_r} - start_r);
    mlen          = month_days(month_r, leap_r);
    month_step    = (month_r < LAST_MONTH) && (left_r >= YDAY_W'(mlen));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_DAYS;
      ST_DAYS:  if (div_rsp.done) state_nxt = ST_HOUR;
      ST_HOUR:  if (div_rsp.done) state_nxt = ST_MIN;
      ST_MIN:   if (div_rsp.done) state_nxt = ST_WDAY;
      ST_WDAY:  if (div_rsp.done) state_nxt = ST_YEAR;
      ST_YEAR: begin
        if (year_past_end) begin
          state_nxt = ST_EMIT;
        end else if (year_hit) begin
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: if (!month_step) state_nxt = ST_EMIT;
      ST_EMIT:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    div_req.start    = 1'b0;
    div_req.op       = DIV_DAY;
    div_req.dividend = '0;
    in_stall         = 1'b1;
    out_load         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall         = !rst_n;
        div_req.start    = in_valid;
        div_req.dividend = in_epoch_seconds;
      end
      ST_DAYS: begin
        div_req.start    = div_rsp.done;
        div_req.op       = DIV_HOUR;
        div_req.dividend = EPOCH_W'(div_rsp.remainder);
      end
      ST_HOUR: begin
        div_req.start    = div_rsp.done;
        div_req.op       = DIV_MIN;
        div_req.dividend = EPOCH_W'(div_rsp.remainder);
      end
      ST_MIN: begin
        div_req.start    = div_rsp.done;
        div_req.op       = DIV_WEEK;
        div_req.dividend = EPOCH_W'(days_r + EPOCH_WEEKDAY);
      end
      ST_EMIT: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_DAYS: if (div_rsp.done) days_r <= div_rsp.quotient;
      ST_HOUR: if (div_rsp.done) hour_r <= div_rsp.quotient[4:0];
      ST_MIN: begin
        if (div_rsp.done) begin
          minute_r <= div_rsp.quotient[5:0];
          second_r <= div_rsp.remainder[5:0];
        end
      end
      ST_WDAY: begin
        if (div_rsp.done) begin
          weekday_r <= div_rsp.remainder[2:0];
          year_r    <= EPOCH_YEAR;
          start_r   <= '0;
        end
      end
      ST_YEAR: begin
        if (year_past_end) begin
          found_r <= 1'b0;
        end else if (year_hit) begin
          found_r <= 1'b1;
          left_r  <= yday_calc;
          yday_r  <= yday_calc;
          leap_r  <= year_leap;
          month_r <= '0;
        end else begin
          start_r <= year_end;
          year_r  <= year_r + YEAR_W'(1);
        end
      end
      ST_MONTH: begin
        if (month_step) begin
          left_r  <= left_r - YDAY_W'(mlen);
          month_r <= month_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_in_range         <= found_r;
      out_years_since_1900 <= found_r ? 8'(year_r - BASE_YEAR) : '0;
      out_month_index      <= found_r ? month_r : '0;
      out_day_of_month     <= found_r ? 5'(left_r + YDAY_W'(1)) : '0;
      out_hour             <= found_r ? hour_r : '0;
      out_minute           <= found_r ? minute_r : '0;
      out_second           <= found_r ? second_r : '0;
      out_weekday          <= found_r ? weekday_r : '0;
      out_year_day         <= found_r ? yday_r : '0;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_fields_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_in_range) |->
      (out_month_index <= 4'd11 && out_day_of_month != 5'd0 && out_hour <= 5'd23 &&
       out_minute <= 6'd59 && out_second <= 6'd59 && out_weekday <= 3'd6))
    else $error("calendar field out of range");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_in_range) |->
      (out_years_since_1900 == '0 && out_month_index == '0 && out_day_of_month == '0 &&
       out_year_day == '0 && out_weekday == '0))
    else $error("out of range result not cleared");

  a_year_walk_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_YEAR) |-> (start_r <= {1'b0, days_r}))
    else $error("year walk passed the day count");

  a_month_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MONTH) |-> (left_r < LEAP_YEAR_DAYS && month_r <= LAST_MONTH))
    else $error("month walk out of bounds");

  a_div_start_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (div_req.start && state_r != ST_IDLE) |-> div_rsp.done)
    else $error("divider restarted while busy");
`endif

endmodule

### tb/sv/tb_epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar
// Self-checking bench for the seconds-to-calendar converter. A directed table
// covers the epoch, the end-year edge, leap days and month ends. Random
// timestamps follow, many of them on day and month boundaries. Every result
// is checked field by field against a fixed expected value or a calendar
// predictor in the bench, while both channels idle at random rates by phase.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar;

  localparam int unsigned END_YEAR   = 2100;
  localparam int unsigned N_RANDOM   = 1600;
  localparam int unsigned DRAIN      = 300;
  localparam int unsigned LIMIT      = 2000000;
  localparam int unsigned DAY_SECS   = 86400;
  localparam int unsigned END_DAYS   = 47482;
  localparam logic [31:0] END_SECS   = 32'd4102444800;

  typedef struct packed {
    logic       in_range;
    logic [7:0] years_since_1900;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
    logic [8:0] yday;
  } date_t;

  typedef struct {
    logic [ect_pkg::EPOCH_W-1:0] secs;
    bit                          known;
    date_t                       want;
  } stim_t;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic        out_in_range;
  logic [7:0]  out_years_since_1900;
  logic [3:0]  out_month_index;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [2:0]  out_weekday;
  logic [8:0]  out_year_day;

  stim_t       epoch_stim[$];
  date_t       expected_dates[$];
  date_t       got_date;
  date_t       want_date;
  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_in_range  = 0;
  int unsigned n_errors    = 0;
  int unsigned cycle_count = 0;

  epoch_seconds_to_calendar #(
    .END_YEAR(END_YEAR)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_epoch_seconds    (in_epoch_seconds),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_in_range        (out_in_range),
    .out_years_since_1900(out_years_since_1900),
    .out_month_index     (out_month_index),
    .out_day_of_month    (out_day_of_month),
    .out_hour            (out_hour),
    .out_minute          (out_minute),
    .out_second          (out_second),
    .out_weekday         (out_weekday),
    .out_year_day        (out_year_day)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit leap_yr(input int unsigned y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4) == 0;
  endfunction

  function automatic int unsigned year_length(input int unsigned y);
    return leap_yr(y) ? 366 : 365;
  endfunction

  function automatic int unsigned month_len(input int unsigned m, input int unsigned y);
    int unsigned len;
    case (m)
      1:       len = leap_yr(y) ? 29 : 28;
      3, 5, 8, 10: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  // calendar fields of a timestamp, all zero past the end year
  function automatic date_t calendar_of(input logic [31:0] secs);
    date_t           d;
    longint unsigned days;
    longint unsigned rem;
    longint unsigned first;
    longint unsigned left;
    int unsigned     yr;
    int unsigned     mon;
    bit              hit;
    d     = '0;
    days  = secs / DAY_SECS;
    rem   = secs % DAY_SECS;
    first = 0;
    yr    = 0;
    hit   = 1'b0;
    for (int unsigned y = 1970; y < END_YEAR && !hit; y++) begin
      if (days < first + year_length(y)) begin
        yr  = y;
        hit = 1'b1;
      end else begin
        first += year_length(y);
      end
    end
    if (!hit) return d;
    left = days - first;
    mon  = 0;
    while (mon < 11 && left >= month_len(mon, yr)) begin
      left -= month_len(mon, yr);
      mon++;
    end
    d.in_range         = 1'b1;
    d.years_since_1900 = 8'(yr - 1900);
    d.month_index      = 4'(mon);
    d.day_of_month     = 5'(left + 1);
    d.hour             = 5'(rem / 3600);
    d.minute           = 6'((rem % 3600) / 60);
    d.second           = 6'(rem % 60);
    d.weekday          = 3'((days + 4) % 7);
    d.yday             = 9'(days - first);
    return d;
  endfunction

  function automatic longint unsigned first_day_of_month(input int unsigned y,
                                                         input int unsigned m);
    longint unsigned d;
    d = 0;
    for (int unsigned k = 1970; k < y; k++) d += year_length(k);
    for (int unsigned k = 0; k < m; k++) d += month_len(k, y);
    return d;
  endfunction

  function automatic date_t date_of(input logic ir, input int unsigned yrs,
                                    input int unsigned mon, input int unsigned mday,
                                    input int unsigned hh, input int unsigned mm,
                                    input int unsigned ss, input int unsigned wd,
                                    input int unsigned yd);
    date_t d;
    d.in_range         = ir;
    d.years_since_1900 = 8'(yrs);
    d.month_index      = 4'(mon);
    d.day_of_month     = 5'(mday);
    d.hour             = 5'(hh);
    d.minute           = 6'(mm);
    d.second           = 6'(ss);
    d.weekday          = 3'(wd);
    d.yday             = 9'(yd);
    return d;
  endfunction

  task automatic add_row(input logic [31:0] secs);
    stim_t s;
    s.secs  = secs;
    s.known = 1'b0;
    s.want  = '0;
    epoch_stim.push_back(s);
  endtask

  task automatic add_known(input logic [31:0] secs, input date_t want);
    stim_t s;
    s.secs  = secs;
    s.known = 1'b1;
    s.want  = want;
    epoch_stim.push_back(s);
  endtask

  task automatic build_stimulus();
    longint unsigned v;
    int unsigned     kind;
    int unsigned     y;
    int unsigned     m;
    // directed table
    add_known(32'd0,          date_of(1'b1, 70, 0, 1, 0, 0, 0, 4, 0));
    add_known(32'd86399,      date_of(1'b1, 70, 0, 1, 23, 59, 59, 4, 0));
    add_known(32'd86400,      date_of(1'b1, 70, 0, 2, 0, 0, 0, 5, 1));
    add_known(32'hFFFF_FFFF,  date_of(1'b0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_known(END_SECS,       date_of(1'b0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(END_SECS - 32'd1);
    add_row(32'd59);
    add_row(32'd60);
    add_row(32'd3599);
    add_row(32'd3600);
    add_row(32'd2592000);
    add_row(32'd2678399);
    add_row(32'd2678400);
    add_row(32'd5011200);
    add_row(32'd68169600);
    add_row(32'd94694399);
    add_row(32'd946684799);
    add_row(32'd946684800);
    add_row(32'd951782400);
    add_row(32'd978220799);
    add_row(32'd2147483647);
    add_row(32'hAAAA_AAAA);
    add_row(32'h5555_5555);
    add_row(32'd4107542400);
    // random part, weighted toward day and month edges
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: v = $urandom;
        3, 4, 5: begin
          v = longint'($urandom_range(0, END_DAYS - 1)) * DAY_SECS;
          case ($urandom_range(0, 2))
            0:       v = v;
            1:       v = v + DAY_SECS - 1;
            default: v = v + $urandom_range(0, DAY_SECS - 1);
          endcase
        end
        6: begin
          y = $urandom_range(1970, END_YEAR - 1);
          m = $urandom_range(0, 11);
          v = first_day_of_month(y, m) * DAY_SECS;
          if (v != 0 && $urandom_range(0, 1)) v = v - 1;
        end
        7: v = longint'(END_SECS) + $urandom_range(0, 200000) - 100000;
        8: v = $urandom_range(0, 200000);
        default: v = 32'hFFFF_FFFF - $urandom_range(0, 1 << 20);
      endcase
      add_row(v[31:0]);
    end
  endtask

  function automatic int unsigned phase_of(input int unsigned n);
    int unsigned p;
    p = (n * 3) / (epoch_stim.size() + 1);
    return (p > 2) ? 2 : p;
  endfunction

  function automatic int unsigned send_idle_pct(input int unsigned n);
    case (phase_of(n))
      0:       return 17;
      1:       return 50;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_idle_pct(input int unsigned n);
    case (phase_of(n))
      0:       return 50;
      1:       return 17;
      default: return 0;
    endcase
  endfunction

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  task automatic compare_dates(input date_t want, input date_t got);
    report_field("in_range",         want.in_range,         got.in_range);
    report_field("years_since_1900", want.years_since_1900, got.years_since_1900);
    report_field("month_index",      want.month_index,      got.month_index);
    report_field("day_of_month",     want.day_of_month,     got.day_of_month);
    report_field("hour",             want.hour,             got.hour);
    report_field("minute",           want.minute,           got.minute);
    report_field("second",           want.second,           got.second);
    report_field("weekday",          want.weekday,          got.weekday);
    report_field("yday",             want.yday,             got.yday);
  endtask

  // input side: record each transfer, then offer the next timestamp
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        if (epoch_stim[n_sent].known) begin
          expected_dates.push_back(epoch_stim[n_sent].want);
        end else begin
          expected_dates.push_back(calendar_of(epoch_stim[n_sent].secs));
        end
        n_sent++;
      end
      if (n_sent < epoch_stim.size() && $urandom_range(0, 99) >= send_idle_pct(n_sent)) begin
        in_valid         <= 1'b1;
        in_epoch_seconds <= epoch_stim[n_sent].secs;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_date = {out_in_range, out_years_since_1900, out_month_index, out_day_of_month,
                    out_hour, out_minute, out_second, out_weekday, out_year_day};
        if (expected_dates.size() == 0) begin
          $display("%0t unexpected transfer: expected none, actual %h", $time, got_date);
          n_errors++;
        end else begin
          want_date = expected_dates.pop_front();
          compare_dates(want_date, got_date);
        end
        if (got_date.in_range) n_in_range++;
        n_checked++;
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct(n_checked));
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", LIMIT,
             expected_dates.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    build_stimulus();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (n_sent < epoch_stim.size() || expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (expected_dates.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, expected_dates.size());
      n_errors++;
    end
    $display("converted %0d timestamps (%0d in range, %0d past end year), %0d errors",
             n_checked, n_in_range, n_checked - n_in_range, n_errors);
    $display("covered epoch, end-year edge, leap days and month ends under three stall mixes");
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
